/* src/u2u_pkg.sv */
package u2u_pkg;

   localparam int unsigned UnitWidth   = 16;
   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned CpWidth     = 21;
   localparam int unsigned MaxResults  = 5;
   localparam int unsigned CountWidth  = $clog2(MaxResults + 1);
   localparam int unsigned IndexWidth  = $clog2(MaxResults);

   localparam logic [5:0]  HighSurTag  = 6'b110110;
   localparam logic [5:0]  LowSurTag   = 6'b110111;
   localparam logic [4:0]  SurTag      = 5'b11011;

   localparam logic [CpWidth-1:0] SuppBase = 21'h010000;
   localparam logic [CpWidth-1:0] TwoByteMin = 21'h000080;
   localparam logic [CpWidth-1:0] ThreeByteMin = 21'h000800;
   localparam logic [CpWidth-1:0] FourByteMin = 21'h010000;

   localparam logic [7:0]  LeadOne     = 8'h00;
   localparam logic [7:0]  LeadTwo     = 8'hC0;
   localparam logic [7:0]  LeadThree   = 8'hE0;
   localparam logic [7:0]  LeadFour    = 8'hF0;
   localparam logic [7:0]  ContTag     = 8'h80;

   localparam logic        StatusOk    = 1'b0;
   localparam logic        StatusBad   = 1'b1;

   typedef struct packed {
      logic [ByteWidth-1:0] out_byte;
      logic                 is_status;
      logic                 status;
   } entry_type;

   typedef struct packed {
      logic [3:0][ByteWidth-1:0] bytes;
      logic [2:0]                len;
   } utf8_type;

   function automatic utf8_type encode(input logic [CpWidth-1:0] cp);
      utf8_type r;
      r.bytes = '0;
      if (cp < TwoByteMin) begin
         r.bytes[0] = LeadOne | {1'b0, cp[6:0]};
         r.len = 3'd1;
      end else if (cp < ThreeByteMin) begin
         r.bytes[0] = LeadTwo | {3'b000, cp[10:6]};
         r.bytes[1] = ContTag | {2'b00, cp[5:0]};
         r.len = 3'd2;
      end else if (cp < FourByteMin) begin
         r.bytes[0] = LeadThree | {4'b0000, cp[15:12]};
         r.bytes[1] = ContTag | {2'b00, cp[11:6]};
         r.bytes[2] = ContTag | {2'b00, cp[5:0]};
         r.len = 3'd3;
      end else begin
         r.bytes[0] = LeadFour | {5'b00000, cp[20:18]};
         r.bytes[1] = ContTag | {2'b00, cp[17:12]};
         r.bytes[2] = ContTag | {2'b00, cp[11:6]};
         r.bytes[3] = ContTag | {2'b00, cp[5:0]};
         r.len = 3'd4;
      end
      return r;
   endfunction

endpackage

/* src/u2u_req_if.sv */
interface u2u_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic        last_unit;

   modport source (output valid, output code_unit, output last_unit, input ready);
   modport sink   (input valid, input code_unit, input last_unit, output ready);
endinterface

/* src/u2u_rsp_if.sv */
interface u2u_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       is_status;
   logic       status;
   logic       run_last;

   modport source (output valid, output out_byte, output is_status, output status,
                   output run_last, input ready);
   modport sink   (input valid, input out_byte, input is_status, input status,
                   input run_last, output ready);
endinterface

/* src/utf16_to_utf8_transcoder.sv */
// Channel   | Direction | Content
// req_chan  | in        | code_unit[15:0], last_unit
// rsp_chan  | out       | out_byte[7:0], is_status, status, run_last
// csr_*     | in        | byte_swap write, one bit
//
// A unit is registered on transfer, then decoded combinationally into a burst of
// up to five results, which leave one per cycle while rsp_chan is ready; a unit
// gives at most four bytes and a status, a plain ASCII unit one byte.
// The next unit enters while the final result of the burst transfers.
// Synchronous active-high reset clears the surrogate and drop state and byte_swap.
// A stall on rsp_chan holds the current result and backs up into req_chan.
module utf16_to_utf8_transcoder (
   input  logic         clock,
   input  logic         reset,
   u2u_req_if.sink      req_chan,
   u2u_rsp_if.source    rsp_chan,
   input  logic         csr_write_en,
   input  logic         csr_write_data
);

   logic                                   swap_ff;
   logic                                   in_valid_ff;
   logic [u2u_pkg::UnitWidth-1:0]          in_unit_ff;
   logic                                   in_last_ff;

   logic [9:0]                             held_ff, held_in;
   logic                                   pending_ff, pending_in;
   logic                                   drop_ff, drop_in;

   u2u_pkg::entry_type [u2u_pkg::MaxResults-1:0] burst_ff, burst_in;
   logic [u2u_pkg::CountWidth-1:0]         count_ff, count_in;
   logic [u2u_pkg::IndexWidth-1:0]         idx_ff;
   logic                                   burst_valid_ff;

   logic                                   on_last;
   logic                                   burst_free;
   logic                                   move;
   logic                                   in_take;

   logic [u2u_pkg::UnitWidth-1:0]          u;
   logic                                   is_sur, is_high, is_low, ends;
   logic                                   do_emit, do_fail, fail_ends, add_status;
   logic [u2u_pkg::CpWidth-1:0]            cp;
   u2u_pkg::utf8_type                      enc;

   assign on_last    = (idx_ff == u2u_pkg::IndexWidth'(count_ff - 1'b1));
   assign burst_free = !burst_valid_ff || (on_last && rsp_chan.ready);
   assign move       = in_valid_ff && burst_free;
   assign req_chan.ready = !in_valid_ff || move;
   assign in_take    = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid     = burst_valid_ff;
   assign rsp_chan.out_byte  = burst_ff[idx_ff].out_byte;
   assign rsp_chan.is_status = burst_ff[idx_ff].is_status;
   assign rsp_chan.status    = burst_ff[idx_ff].status;
   assign rsp_chan.run_last  = on_last;

   always_comb begin
      u = swap_ff ? {in_unit_ff[7:0], in_unit_ff[15:8]} : in_unit_ff;
      is_sur  = (u[15:11] == u2u_pkg::SurTag);
      is_high = (u[15:10] == u2u_pkg::HighSurTag);
      is_low  = (u[15:10] == u2u_pkg::LowSurTag);
      ends    = in_last_ff || (u == '0);

      held_in    = held_ff;
      pending_in = pending_ff;
      drop_in    = drop_ff;
      do_emit    = 1'b0;
      do_fail    = 1'b0;
      fail_ends  = 1'b0;
      add_status = 1'b0;
      cp         = {5'b00000, u};

      if (drop_ff) begin
         if (ends) begin
            drop_in = 1'b0;
         end
      end else if (pending_ff) begin
         if (!is_low) begin
            do_fail   = 1'b1;
            fail_ends = ends;
         end else begin
            cp         = u2u_pkg::SuppBase + {1'b0, held_ff, u[9:0]};
            pending_in = 1'b0;
            held_in    = '0;
            do_emit    = 1'b1;
            add_status = in_last_ff;
         end
      end else if (is_high) begin
         if (in_last_ff) begin
            do_fail   = 1'b1;
            fail_ends = 1'b1;
         end else begin
            pending_in = 1'b1;
            held_in    = u[9:0];
         end
      end else if (is_sur) begin
         do_fail   = 1'b1;
         fail_ends = ends;
      end else if (u == '0) begin
         add_status = 1'b1;
      end else begin
         do_emit    = 1'b1;
         add_status = in_last_ff;
      end

      if (do_fail) begin
         pending_in = 1'b0;
         held_in    = '0;
         drop_in    = !fail_ends;
      end

      enc = u2u_pkg::encode(cp);

      for (int i = 0; i < u2u_pkg::MaxResults; i++) begin
         burst_in[i] = '0;
      end
      count_in = '0;
      if (do_fail) begin
         burst_in[0].is_status = 1'b1;
         burst_in[0].status    = u2u_pkg::StatusBad;
         count_in = u2u_pkg::CountWidth'(1);
      end else begin
         if (do_emit) begin
            for (int i = 0; i < 4; i++) begin
               if (3'(i) < enc.len) begin
                  burst_in[i].out_byte = enc.bytes[i];
               end
            end
            count_in = u2u_pkg::CountWidth'(enc.len);
         end
         if (add_status) begin
            for (int i = 0; i < u2u_pkg::MaxResults; i++) begin
               if (u2u_pkg::CountWidth'(i) == count_in) begin
                  burst_in[i].is_status = 1'b1;
                  burst_in[i].status    = u2u_pkg::StatusOk;
               end
            end
            count_in = count_in + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         swap_ff        <= 1'b0;
         in_valid_ff    <= 1'b0;
         held_ff        <= '0;
         pending_ff     <= 1'b0;
         drop_ff        <= 1'b0;
         burst_valid_ff <= 1'b0;
         idx_ff         <= '0;
         count_ff       <= '0;
      end else begin
         if (csr_write_en) begin
            swap_ff <= csr_write_data;
         end
         if (in_take) begin
            in_valid_ff <= 1'b1;
         end else if (move) begin
            in_valid_ff <= 1'b0;
         end
         if (move) begin
            held_ff        <= held_in;
            pending_ff     <= pending_in;
            drop_ff        <= drop_in;
            burst_valid_ff <= (count_in != '0);
            count_ff       <= count_in;
            idx_ff         <= '0;
         end else if (burst_valid_ff && rsp_chan.ready) begin
            if (on_last) begin
               burst_valid_ff <= 1'b0;
            end else begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         in_unit_ff <= req_chan.code_unit;
         in_last_ff <= req_chan.last_unit;
      end
      if (move) begin
         burst_ff <= burst_in;
      end
   end

endmodule
